[hw/rtl/fmfa_pkg.sv]
// Shared types, constants and float helpers for the multi-frame averager.
// No dependencies; imported by every module of the block.
package fmfa_pkg;

    localparam int MAX_CHANNELS = 65536;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = CH_W + 1;
    localparam int FRM_W        = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd1;
    localparam logic [1:0] REG_SCALE_BITS    = 2'd2;

    localparam logic [31:0] QNAN32     = 32'h7FC0_0000;
    localparam logic [31:0] ONE32      = 32'h3F80_0000;
    localparam logic [15:0] QNAN16     = 16'h7E00;
    localparam logic [CNT_W-1:0] RESET_CHANNELS = CNT_W'(4);
    localparam logic [FRM_W-1:0] RESET_FRAMES   = FRM_W'(1);

    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] pos;
        logic            last_frame;
        logic            last_chan;
    } fmfa_tag_t;

    // binary16 to binary32, exact
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] res;
        logic [3:0]  hi;
        logic [9:0]  m;
        logic [7:0]  e;
        begin
            hi = 4'd0;
            m  = h[9:0];
            for (int i = 0; i < 10; i++)
            begin
                if (h[i])
                begin
                    hi = 4'(i);
                end
            end
            if (h[14:10] == 5'h1F)
            begin
                res = {h[15], 8'hFF, h[9:0], 13'd0};
            end
            else if (h[14:10] == 5'd0)
            begin
                if (h[9:0] == 10'd0)
                begin
                    res = {h[15], 31'd0};
                end
                else
                begin
                    m   = 10'(h[9:0] << (4'd10 - hi));
                    e   = 8'd103 + 8'(hi);
                    res = {h[15], e, m, 13'd0};
                end
            end
            else
            begin
                e   = 8'(h[14:10]) + 8'd112;
                res = {h[15], e, h[9:0], 13'd0};
            end
            return res;
        end
    endfunction

    // binary32 to binary16, nearest even, NaN made canonical
    function automatic logic [15:0] narrow_float(input logic [31:0] u);
        logic [15:0] res;
        logic [7:0]  e;
        logic [7:0]  s;
        logic [22:0] m;
        logic [23:0] full;
        logic [23:0] rem;
        logic [23:0] half;
        logic [15:0] r;
        logic [12:0] rem13;
        begin
            e     = u[30:23];
            m     = u[22:0];
            s     = 8'd126 - e;
            full  = {1'b1, m};
            rem13 = m[12:0];
            r     = 16'd0;
            rem   = 24'd0;
            half  = 24'd0;
            if (e == 8'hFF)
            begin
                res = (m != 23'd0) ? QNAN16 : {u[31], 15'h7C00};
            end
            else if (e == 8'd0)
            begin
                res = {u[31], 15'd0};
            end
            else if (e >= 8'd143)
            begin
                res = {u[31], 15'h7C00};
            end
            else if (e >= 8'd113)
            begin
                r = {1'b0, 5'(e - 8'd112), m[22:13]};
                if (rem13 > 13'h1000 || (rem13 == 13'h1000 && r[0]))
                begin
                    r = r + 16'd1;
                end
                if (r >= 16'h7C00)
                begin
                    r = 16'h7C00;
                end
                res = {u[31], r[14:0]};
            end
            else if (s >= 8'd25)
            begin
                res = {u[31], 15'd0};
            end
            else
            begin
                r    = 16'(full >> s[4:0]);
                rem  = full & ~(24'hFFFFFF << s[4:0]);
                half = 24'd1 << (s[4:0] - 5'd1);
                if (rem > half || (rem == half && r[0]))
                begin
                    r = r + 16'd1;
                end
                res = {u[31], r[14:0]};
            end
            return res;
        end
    endfunction

endpackage

[hw/rtl/fmfa_add.sv]
// Four-stage binary32 adder, round to nearest even, with tags riding along.
// Depends on fmfa_pkg.
module fmfa_add (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  fmfa_pkg::fmfa_tag_t          in_tag,
    input  logic [31:0]                  a_bits,
    input  logic [31:0]                  b_bits,
    output fmfa_pkg::fmfa_tag_t [3:0]    stage_tag,
    output logic [31:0]                  sum_bits
);
    import fmfa_pkg::*;

    // stage 1: unpack, specials, order by magnitude
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_ge;
    logic [7:0]  ea, eb, xa, xb;
    logic        spec_next, sign_next, sub_next, zsign_next;
    logic [31:0] spec_val_next;
    logic [7:0]  xl_next, d_next;
    logic [23:0] fl_next, fs_next;

    logic        spec2_reg, sign2_reg, sub2_reg, zsign2_reg;
    logic [31:0] spec_val2_reg;
    logic [7:0]  xl2_reg, d2_reg;
    logic [23:0] fl2_reg, fs2_reg;

    always_comb
    begin
        sa    = a_bits[31];
        sb    = b_bits[31];
        ea    = a_bits[30:23];
        eb    = b_bits[30:23];
        a_nan = (ea == 8'hFF) && (a_bits[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b_bits[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a_bits[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b_bits[22:0] == 23'd0);
        xa    = (ea == 8'd0) ? 8'd1 : ea;
        xb    = (eb == 8'd0) ? 8'd1 : eb;
        a_ge  = a_bits[30:0] >= b_bits[30:0];

        spec_next     = a_nan || b_nan || a_inf || b_inf;
        spec_val_next = (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) ? QNAN32 :
                        (a_inf ? a_bits : b_bits);
        sub_next      = sa ^ sb;
        zsign_next    = sa & sb;
        sign_next     = a_ge ? sa : sb;
        xl_next       = a_ge ? xa : xb;
        d_next        = a_ge ? (xa - xb) : (xb - xa);
        fl_next       = a_ge ? {ea != 8'd0, a_bits[22:0]} : {eb != 8'd0, b_bits[22:0]};
        fs_next       = a_ge ? {eb != 8'd0, b_bits[22:0]} : {ea != 8'd0, a_bits[22:0]};
    end

    // stage 2: align the smaller operand, keep a sticky bit
    logic [26:0] ext, al_next, shifted;
    logic        lost;
    logic [26:0] al3_reg, fl3_reg;
    logic        spec3_reg, sign3_reg, sub3_reg, zsign3_reg;
    logic [31:0] spec_val3_reg;
    logic [7:0]  xl3_reg;

    always_comb
    begin
        ext     = {fs2_reg, 3'b000};
        shifted = ext >> d2_reg[4:0];
        lost    = |(ext & ~(27'h7FF_FFFF << d2_reg[4:0]));
        if (d2_reg >= 8'd27)
        begin
            al_next = {26'd0, |fs2_reg};
        end
        else
        begin
            al_next = shifted | {26'd0, lost};
        end
    end

    // stage 3: add or subtract magnitudes
    logic [27:0] s_next, s4_reg;
    logic        spec4_reg, sign4_reg, zsign4_reg;
    logic [31:0] spec_val4_reg;
    logic [7:0]  xl4_reg;

    always_comb
    begin
        if (sub3_reg)
        begin
            s_next = {1'b0, fl3_reg} - {1'b0, al3_reg};
        end
        else
        begin
            s_next = {1'b0, fl3_reg} + {1'b0, al3_reg};
        end
    end

    // stage 4: leading zero count and normalize
    logic [4:0]  hi;
    logic [4:0]  lz;
    logic [7:0]  lim, sh;
    logic [26:0] m_next, m5_reg;
    logic [8:0]  e_next, e5_reg;
    logic        zero_next, zero5_reg;
    logic        spec5_reg, sign5_reg, zsign5_reg;
    logic [31:0] spec_val5_reg;

    always_comb
    begin
        hi = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (s4_reg[i])
            begin
                hi = 5'(i);
            end
        end
        lz        = 5'd26 - hi;
        lim       = xl4_reg - 8'd1;
        sh        = (8'(lz) < lim) ? 8'(lz) : lim;
        zero_next = (s4_reg == 28'd0);
        if (s4_reg[27])
        begin
            m_next = {s4_reg[27:2], |s4_reg[1:0]};
            e_next = 9'(xl4_reg) + 9'd1;
        end
        else
        begin
            m_next = s4_reg[26:0] << sh[4:0];
            e_next = 9'(xl4_reg) - 9'(sh);
        end
    end

    // stage 5: round and pack
    logic        inc;
    logic [24:0] r25;
    logic [23:0] mant;
    logic [8:0]  e_fin;

    always_comb
    begin
        inc   = m5_reg[2] && ((|m5_reg[1:0]) || m5_reg[3]);
        r25   = {1'b0, m5_reg[26:3]} + 25'(inc);
        mant  = r25[24] ? r25[24:1] : r25[23:0];
        e_fin = r25[24] ? (e5_reg + 9'd1) : e5_reg;
        if (spec5_reg)
        begin
            sum_bits = spec_val5_reg;
        end
        else if (zero5_reg)
        begin
            sum_bits = {zsign5_reg, 31'd0};
        end
        else if (e_fin >= 9'd255)
        begin
            sum_bits = {sign5_reg, 8'hFF, 23'd0};
        end
        else
        begin
            sum_bits = {sign5_reg, (mant[23] ? e_fin[7:0] : 8'd0), mant[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_tag <= '0;
        end
        else if (en)
        begin
            stage_tag <= {stage_tag[2:0], in_tag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec2_reg     <= spec_next;
            spec_val2_reg <= spec_val_next;
            sign2_reg     <= sign_next;
            sub2_reg      <= sub_next;
            zsign2_reg    <= zsign_next;
            xl2_reg       <= xl_next;
            d2_reg        <= d_next;
            fl2_reg       <= fl_next;
            fs2_reg       <= fs_next;

            al3_reg       <= al_next;
            fl3_reg       <= {fl2_reg, 3'b000};
            spec3_reg     <= spec2_reg;
            spec_val3_reg <= spec_val2_reg;
            sign3_reg     <= sign2_reg;
            sub3_reg      <= sub2_reg;
            zsign3_reg    <= zsign2_reg;
            xl3_reg       <= xl2_reg;

            s4_reg        <= s_next;
            spec4_reg     <= spec3_reg;
            spec_val4_reg <= spec_val3_reg;
            sign4_reg     <= sign3_reg;
            zsign4_reg    <= zsign3_reg;
            xl4_reg       <= xl3_reg;

            m5_reg        <= m_next;
            e5_reg        <= e_next;
            zero5_reg     <= zero_next;
            spec5_reg     <= spec4_reg;
            spec_val5_reg <= spec_val4_reg;
            sign5_reg     <= sign4_reg;
            zsign5_reg    <= zsign4_reg;
        end
    end

endmodule

[hw/rtl/fmfa_mul.sv]
// Two-stage binary32 scale multiply, then narrowing to binary16.
// Depends on fmfa_pkg (narrow_float, constants).
module fmfa_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic        in_last,
    input  logic [31:0] sum_bits,
    input  logic [31:0] scale_bits,
    output logic        out_valid,
    output logic        out_last,
    output logic [15:0] out_half
);
    import fmfa_pkg::*;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_INF    = 2'd2,
        CLS_NAN    = 2'd3
    } mul_cls_t;

    logic        s_nan, c_nan, s_inf, c_inf, s_zero, c_zero, s_tiny, c_tiny;
    mul_cls_t    cls_next, cls1_reg;
    logic [47:0] p_next, p1_reg;
    logic [10:0] e_next, e1_reg;
    logic        sign1_reg, valid1_reg, last1_reg;

    always_comb
    begin
        s_nan  = (sum_bits[30:23] == 8'hFF) && (sum_bits[22:0] != 23'd0);
        c_nan  = (scale_bits[30:23] == 8'hFF) && (scale_bits[22:0] != 23'd0);
        s_inf  = (sum_bits[30:23] == 8'hFF) && (sum_bits[22:0] == 23'd0);
        c_inf  = (scale_bits[30:23] == 8'hFF) && (scale_bits[22:0] == 23'd0);
        s_zero = (sum_bits[30:0] == 31'd0);
        c_zero = (scale_bits[30:0] == 31'd0);
        s_tiny = (sum_bits[30:23] == 8'd0);
        c_tiny = (scale_bits[30:23] == 8'd0);
        // Subnormal operands are flushed, so unless paired with a NaN or infinity they give a signed zero.
        if (s_nan || c_nan || (s_inf && c_zero) || (c_inf && s_zero))
        begin
            cls_next = CLS_NAN;
        end
        else if (s_inf || c_inf)
        begin
            cls_next = CLS_INF;
        end
        else if (s_tiny || c_tiny)
        begin
            cls_next = CLS_ZERO;
        end
        else
        begin
            cls_next = CLS_NORMAL;
        end
        p_next = {1'b1, sum_bits[22:0]} * {1'b1, scale_bits[22:0]};
        e_next = 11'(sum_bits[30:23]) + 11'(scale_bits[30:23]) - 11'd127;
    end

    // round product to binary32
    logic [23:0] mant;
    logic        g, st, inc;
    logic [24:0] r25;
    logic [10:0] e_a, e_b;
    logic [31:0] f_next, f2_reg;
    logic        valid2_reg, last2_reg;

    always_comb
    begin
        if (p1_reg[47])
        begin
            mant = p1_reg[47:24];
            g    = p1_reg[23];
            st   = |p1_reg[22:0];
            e_a  = e1_reg + 11'd1;
        end
        else
        begin
            mant = p1_reg[46:23];
            g    = p1_reg[22];
            st   = |p1_reg[21:0];
            e_a  = e1_reg;
        end
        inc = g && (st || mant[0]);
        r25 = {1'b0, mant} + 25'(inc);
        e_b = r25[24] ? (e_a + 11'd1) : e_a;
        case (cls1_reg)
            CLS_NAN:  f_next = QNAN32;
            CLS_INF:  f_next = {sign1_reg, 8'hFF, 23'd0};
            CLS_ZERO: f_next = {sign1_reg, 31'd0};
            default:
            begin
                if ($signed(e_b) >= 11'sd255)
                begin
                    f_next = {sign1_reg, 8'hFF, 23'd0};
                end
                else if ($signed(e_b) <= 11'sd0)
                begin
                    f_next = {sign1_reg, 31'd0};
                end
                else
                begin
                    f_next = {sign1_reg, e_b[7:0],
                              (r25[24] ? r25[23:1] : r25[22:0])};
                end
            end
        endcase
    end

    assign out_valid = valid2_reg;
    assign out_last  = last2_reg;
    assign out_half  = narrow_float(f2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls1_reg  <= cls_next;
            p1_reg    <= p_next;
            e1_reg    <= e_next;
            sign1_reg <= sum_bits[31] ^ scale_bits[31];
            last1_reg <= in_last;
            f2_reg    <= f_next;
            last2_reg <= last1_reg;
        end
    end

endmodule

[hw/rtl/fp16_multi_frame_averager_top.sv]
// Multi-frame fp16 averager: binary32 per-channel sums, scaled and narrowed on the last frame.
// Path: stage 1, the adder stages, stage 6, the multiplier stages, then the output register.
// Throughput: one beat per cycle while channel_count is 6 or more and the output is not held;
//   a sample that reads a sum still in the 5-stage read/add window waits, so fewer channels stall.
// Reset: counters and registers return to their reset values; the sum memory is not cleared,
//   since the first frame of each accumulation adds to +0.0 and never reads it.
// Depends on fmfa_pkg, fmfa_add, fmfa_mul.
module fp16_multi_frame_averager_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample_half,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] average_half,
    output logic        frame_last
);
    import fmfa_pkg::*;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] channel_count_reg;
    logic [FRM_W-1:0] sample_count_reg;
    logic [31:0]      scale_reg;
    logic [CNT_W-1:0] chan_eff;
    logic [CNT_W-1:0] frm_eff;
    logic             rearm;

    assign rearm = cfg_write && ((cfg_index == REG_CHANNEL_COUNT) ||
                                 (cfg_index == REG_SAMPLE_COUNT));

    // zero counts act as one; oversized channel counts clamp to the memory depth
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            chan_eff = CNT_W'(1);
        end
        else if (channel_count_reg > CNT_W'(MAX_CHANNELS))
        begin
            chan_eff = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            chan_eff = channel_count_reg;
        end
        frm_eff = (sample_count_reg == '0) ? CNT_W'(1) : CNT_W'(sample_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= RESET_CHANNELS;
            sample_count_reg  <= RESET_FRAMES;
            scale_reg         <= ONE32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CNT_W-1:0];
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[FRM_W-1:0];
                REG_SCALE_BITS:    scale_reg         <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // The whole pipe moves together; it only freezes when the output beat is held.
    logic                out_valid_reg;
    logic                adv;
    logic                hazard;
    logic                accept;
    fmfa_tag_t           s1_tag_reg;
    fmfa_tag_t [3:0]     add_tag;

    assign adv    = !out_valid_reg || !out_stall;
    assign accept = in_valid && !in_stall;

    // ---------------- position / frame counters ----------------
    logic [CH_W-1:0]  pos_reg, pos_next;
    logic [FRM_W-1:0] frames_reg, frames_next;
    logic [CH_W-1:0]  pos_now;
    logic             first_now, last_frame_now, last_chan_now;

    always_comb
    begin
        pos_now        = (CNT_W'(pos_reg) >= chan_eff) ? '0 : pos_reg;
        first_now      = (frames_reg == '0);
        last_frame_now = (CNT_W'(frames_reg) + CNT_W'(1)) >= frm_eff;
        last_chan_now  = (CNT_W'(pos_now) + CNT_W'(1)) >= chan_eff;
        if (last_chan_now)
        begin
            pos_next    = '0;
            frames_next = last_frame_now ? '0 : (frames_reg + FRM_W'(1));
        end
        else
        begin
            pos_next    = pos_now + CH_W'(1);
            frames_next = frames_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
        end
        else if (rearm)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            frames_reg <= frames_next;
        end
    end

    // A later frame must not read a sum whose update is still in flight
    // (stage 1 through the adder's write-back stage).
    always_comb
    begin
        hazard = s1_tag_reg.valid && (s1_tag_reg.pos == pos_now);
        for (int i = 0; i < 4; i++)
        begin
            if (add_tag[i].valid && (add_tag[i].pos == pos_now))
            begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && !first_now;
    end

    assign in_stall = !adv || hazard;

    // ---------------- sum memory and stage 1 ----------------
    logic [31:0] sum_mem [MAX_CHANNELS];
    logic [31:0] rd_reg;
    logic [31:0] v1_reg;
    logic        first1_reg;
    logic [31:0] add_sum;
    fmfa_tag_t   s1_tag_next;

    always_comb
    begin
        s1_tag_next.valid      = accept;
        s1_tag_next.pos        = pos_now;
        s1_tag_next.last_frame = last_frame_now;
        s1_tag_next.last_chan  = last_chan_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg <= s1_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= sum_mem[pos_now];
            v1_reg     <= widen_half(sample_half);
            first1_reg <= first_now;
        end
        // write-back from the adder's last stage
        if (adv && add_tag[3].valid)
        begin
            sum_mem[add_tag[3].pos] <= add_sum;
        end
    end

    // ---------------- accumulate ----------------
    fmfa_add u_add (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_tag    (s1_tag_reg),
        .a_bits    (first1_reg ? 32'd0 : rd_reg),
        .b_bits    (v1_reg),
        .stage_tag (add_tag),
        .sum_bits  (add_sum)
    );

    // ---------------- stage 6: finished sum ----------------
    logic        s6_valid_reg;
    logic        s6_last_reg;
    logic [31:0] s6_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // only last-frame items produce a result beat
            s6_valid_reg <= add_tag[3].valid && add_tag[3].last_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_last_reg <= add_tag[3].last_chan;
            s6_sum_reg  <= add_sum;
        end
    end

    // ---------------- scale and narrow ----------------
    logic        m_valid;
    logic        m_last;
    logic [15:0] m_half;

    fmfa_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s6_valid_reg),
        .in_last    (s6_last_reg),
        .sum_bits   (s6_sum_reg),
        .scale_bits (scale_reg),
        .out_valid  (m_valid),
        .out_last   (m_last),
        .out_half   (m_half)
    );

    // ---------------- output register ----------------
    logic [15:0] average_half_reg;
    logic        frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && m_valid)
        begin
            average_half_reg <= m_half;
            frame_last_reg   <= m_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign average_half = average_half_reg;
    assign frame_last   = frame_last_reg;

    // ---------------- assertions ----------------
    a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rearm |=> (pos_reg == '0) && (frames_reg == '0))
        else $error("rearm did not clear the counters");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(pos_reg) < chan_eff)
        else $error("channel position beyond channel count");

    a_frames_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(frames_reg) < frm_eff)
        else $error("frame counter beyond sample count");

endmodule
